// ===== rtl/pap_pkg.sv =====
// ----------------------------------------------------------------------------
// pap_pkg
// Shared types and constants for the polygon axis projection block.
// ----------------------------------------------------------------------------
package pap_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int INDEX_CAP    = (MAX_VERTICES - 1 < 255) ? MAX_VERTICES - 1 : 255;

    // Queue between the transform pipeline and the min/max tracker.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int PIPE_DEPTH = 6;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_COS  = 3'd0;
    localparam logic [2:0] REG_SIN  = 3'd1;
    localparam logic [2:0] REG_SCX  = 3'd2;
    localparam logic [2:0] REG_SCY  = 3'd3;
    localparam logic [2:0] REG_POSX = 3'd4;
    localparam logic [2:0] REG_POSY = 3'd5;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] proj;
        logic               last;
    } t_proj_item;

    typedef struct packed {
        logic signed [31:0] min_projection;
        logic        [7:0]  min_index;
        logic signed [31:0] max_projection;
        logic        [7:0]  max_index;
    } t_result;

    // Saturate a sign-extended value to 32 bit signed.
    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        hi = 65'sd2147483647;
        lo = -65'sd2147483648;
        if (x > hi) begin
            return 32'sh7fffffff;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== rtl/pap_front.sv =====
// ----------------------------------------------------------------------------
// pap_front
// Accepts vertices and runs the six-stage transform and projection pipeline.
// ----------------------------------------------------------------------------
module pap_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pap_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_vertex_x,
    input  logic signed [31:0]   i_vertex_y,
    input  logic signed [31:0]   i_ray_start_x,
    input  logic signed [31:0]   i_ray_start_y,
    input  logic signed [31:0]   i_ray_dir_x,
    input  logic signed [31:0]   i_ray_dir_y,
    input  logic                 i_last_vertex,
    input  logic                 i_pop,
    output logic                 o_push,
    output pap_pkg::t_proj_item  o_push_item
);
    import pap_pkg::*;

    // Items in the pipeline plus items in the queue. The pipeline never
    // stalls, so a vertex is taken only while a queue slot is reserved.
    logic [FIFO_CW-1:0]    r_used;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  accept;

    logic signed [47:0] r1_px, r1_py;
    logic signed [31:0] r1_rsx, r1_rsy, r1_rdx, r1_rdy;
    logic signed [31:0] r2_rsx, r2_rsy, r2_rdx, r2_rdy;
    logic signed [31:0] r3_rsx, r3_rsy, r3_rdx, r3_rdy;
    logic signed [31:0] r4_rdx, r4_rdy;
    logic signed [55:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [31:0] r3_wx, r3_wy;
    logic signed [31:0] r4_dx, r4_dy;
    logic signed [63:0] r5_p1, r5_p2;
    logic signed [31:0] r6_proj;
    logic [PIPE_DEPTH-1:0] r_last;

    logic signed [39:0] sx, sy;
    logic signed [56:0] tx, ty;
    logic signed [42:0] rx, ry;
    logic signed [43:0] wx_sum, wy_sum;
    logic signed [32:0] dx_sum, dy_sum;
    logic signed [64:0] p_sum;
    logic signed [48:0] p_shift;

    assign o_ready = (r_used < FIFO_CW'(FIFO_DEPTH));
    assign accept  = i_valid && o_ready;

    assign sx     = r1_px[47:8];
    assign sy     = r1_py[47:8];
    assign tx     = 57'(r2_a) - 57'(r2_b);
    assign ty     = 57'(r2_c) + 57'(r2_d);
    assign rx     = tx[56:14];
    assign ry     = ty[56:14];
    assign wx_sum = 44'(rx) + 44'(i_cfg.position_x);
    assign wy_sum = 44'(ry) + 44'(i_cfg.position_y);
    assign dx_sum = 33'(r3_wx) - 33'(r3_rsx);
    assign dy_sum = 33'(r3_wy) - 33'(r3_rsy);
    assign p_sum  = 65'(r5_p1) + 65'(r5_p2);
    assign p_shift = p_sum[64:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_vld  <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], accept};
            if (accept && !i_pop) begin
                r_used <= r_used + 1'b1;
            end else if (!accept && i_pop) begin
                r_used <= r_used - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 1: per-axis scale.
        r1_px  <= i_vertex_x * i_cfg.scale_x;
        r1_py  <= i_vertex_y * i_cfg.scale_y;
        r1_rsx <= i_ray_start_x;
        r1_rsy <= i_ray_start_y;
        r1_rdx <= i_ray_dir_x;
        r1_rdy <= i_ray_dir_y;
        r_last <= {r_last[PIPE_DEPTH-2:0], i_last_vertex};
        // Stage 2: rotation products.
        r2_a   <= sx * i_cfg.cos_angle;
        r2_b   <= sy * i_cfg.sin_angle;
        r2_c   <= sy * i_cfg.cos_angle;
        r2_d   <= sx * i_cfg.sin_angle;
        r2_rsx <= r1_rsx;
        r2_rsy <= r1_rsy;
        r2_rdx <= r1_rdx;
        r2_rdy <= r1_rdy;
        // Stage 3: translate to world and saturate.
        r3_wx  <= sat32(65'(wx_sum));
        r3_wy  <= sat32(65'(wy_sum));
        r3_rsx <= r2_rsx;
        r3_rsy <= r2_rsy;
        r3_rdx <= r2_rdx;
        r3_rdy <= r2_rdy;
        // Stage 4: offset from the ray start.
        r4_dx  <= sat32(65'(dx_sum));
        r4_dy  <= sat32(65'(dy_sum));
        r4_rdx <= r3_rdx;
        r4_rdy <= r3_rdy;
        // Stage 5: dot product terms.
        r5_p1  <= r4_dx * r4_rdx;
        r5_p2  <= r4_dy * r4_rdy;
        // Stage 6: exact sum, floor shift, saturate.
        r6_proj <= sat32(65'(p_shift));
    end

    assign o_push           = r_vld[PIPE_DEPTH-1];
    assign o_push_item.proj = r6_proj;
    assign o_push_item.last = r_last[PIPE_DEPTH-1];

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FIFO_CW'(FIFO_DEPTH))
        else $error("reservation count exceeds queue depth");

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) <= int'(r_used))
        else $error("pipeline holds more items than reserved");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_vld[0])
        else $error("accepted vertex did not enter the pipeline");

endmodule

// ===== rtl/pap_fifo.sv =====
// ----------------------------------------------------------------------------
// pap_fifo
// Short queue of projections between the pipeline and the min/max tracker.
// ----------------------------------------------------------------------------
module pap_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pap_pkg::t_proj_item  i_push_item,
    input  logic                 i_pop,
    output logic                 o_empty,
    output pap_pkg::t_proj_item  o_head
);
    import pap_pkg::*;

    t_proj_item         r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < FIFO_CW'(FIFO_DEPTH)) || i_pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/pap_back.sv =====
// ----------------------------------------------------------------------------
// pap_back
// Tracks running min and max projection with indices and holds the result.
// ----------------------------------------------------------------------------
module pap_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  pap_pkg::t_proj_item  i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pap_pkg::t_result     o_result
);
    import pap_pkg::*;

    logic signed [31:0] r_min, r_max, n_min, n_max;
    logic [7:0]         r_min_idx, r_max_idx, n_min_idx, n_max_idx;
    logic [7:0]         r_count;
    logic               r_out_valid;
    t_result            r_out;
    logic               first;

    // A non-last vertex may update the running state while a result waits.
    assign o_pop = !i_empty && (!i_head.last || !r_out_valid || i_ready);
    assign first = (r_count == '0);

    always_comb begin
        n_min     = r_min;
        n_min_idx = r_min_idx;
        n_max     = r_max;
        n_max_idx = r_max_idx;
        if (first || i_head.proj < r_min) begin
            n_min     = i_head.proj;
            n_min_idx = r_count;
        end
        if (first || i_head.proj > r_max) begin
            n_max     = i_head.proj;
            n_max_idx = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= '0;
            r_max       <= '0;
            r_min_idx   <= '0;
            r_max_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_head.last) begin
                    r_min       <= '0;
                    r_max       <= '0;
                    r_min_idx   <= '0;
                    r_max_idx   <= '0;
                    r_count     <= '0;
                end else begin
                    r_min     <= n_min;
                    r_max     <= n_max;
                    r_min_idx <= n_min_idx;
                    r_max_idx <= n_max_idx;
                    if (r_count < 8'(INDEX_CAP)) begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_out.min_projection <= n_min;
            r_out.min_index      <= n_min_idx;
            r_out.max_projection <= n_max;
            r_out.max_index      <= n_max_idx;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 8'(INDEX_CAP))
        else $error("vertex counter passed its cap");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.last |-> !r_out_valid || i_ready)
        else $error("result overwritten before it was taken");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.last |=> r_count == '0 && r_out_valid)
        else $error("polygon did not restart after its result");

endmodule

// ===== rtl/polygon_axis_projection_top.sv =====
// ----------------------------------------------------------------------------
// polygon_axis_projection_top
// Projects a streamed polygon onto a ray and reports min and max projection.
// ----------------------------------------------------------------------------
// Usage: vertices arrive one request at a time on the input channel
// (i_valid / o_ready), each with the ray start and direction and a flag on
// the final vertex. Each vertex is scaled, rotated and translated by the
// configuration registers, then projected onto the ray. The final vertex
// of a polygon produces one result request on the output channel
// (o_valid / i_ready) with the min and max projection and their indices.
// Throughput is one vertex per cycle while a queue slot is free. The
// six-stage transform pipeline feeds an eight-entry queue, and a vertex
// is taken only while a queue slot is free, so the queue depth sets how
// far the pipeline may run ahead of the tracker. While the receiver
// stalls, the result is held and vertices of the next polygon keep
// flowing until its final vertex reaches the tracker or the queue fills.
// Reset clears the registers to identity transform and starts a new
// polygon. The user must write registers over the APB-style port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module polygon_axis_projection_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_ray_start_x,
    input  logic signed [31:0] i_ray_start_y,
    input  logic signed [31:0] i_ray_dir_x,
    input  logic signed [31:0] i_ray_dir_y,
    input  logic               i_last_vertex,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_min_projection,
    output logic        [7:0]  o_min_index,
    output logic signed [31:0] o_max_projection,
    output logic        [7:0]  o_max_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);
    import pap_pkg::*;

    t_cfg        r_cfg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic        pop, push, empty;
    t_proj_item  push_item, head;
    t_result     result;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_angle  <= 16'sd16384;
            r_cfg.sin_angle  <= '0;
            r_cfg.scale_x    <= 16'sd256;
            r_cfg.scale_y    <= 16'sd256;
            r_cfg.position_x <= '0;
            r_cfg.position_y <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COS:  r_cfg.cos_angle  <= pwdata[15:0];
                REG_SIN:  r_cfg.sin_angle  <= pwdata[15:0];
                REG_SCX:  r_cfg.scale_x    <= pwdata[15:0];
                REG_SCY:  r_cfg.scale_y    <= pwdata[15:0];
                REG_POSX: r_cfg.position_x <= pwdata;
                REG_POSY: r_cfg.position_y <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COS:  prdata = 32'(r_cfg.cos_angle);
            REG_SIN:  prdata = 32'(r_cfg.sin_angle);
            REG_SCX:  prdata = 32'(r_cfg.scale_x);
            REG_SCY:  prdata = 32'(r_cfg.scale_y);
            REG_POSX: prdata = r_cfg.position_x;
            REG_POSY: prdata = r_cfg.position_y;
            default:  prdata = '0;
        endcase
    end

    pap_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_ray_start_x (i_ray_start_x),
        .i_ray_start_y (i_ray_start_y),
        .i_ray_dir_x   (i_ray_dir_x),
        .i_ray_dir_y   (i_ray_dir_y),
        .i_last_vertex (i_last_vertex),
        .i_pop         (pop),
        .o_push        (push),
        .o_push_item   (push_item)
    );

    pap_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_head      (head)
    );

    pap_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_min_projection = result.min_projection;
    assign o_min_index      = result.min_index;
    assign o_max_projection = result.max_projection;
    assign o_max_index      = result.max_index;

endmodule
